// File: rtl/rrc_pkg.sv
// shared constants of the random replacement object cache
`default_nettype none
package rrc_pkg;
   localparam int ENTRIES_DEFAULT = 4096;
   localparam int ID_W = 32;
   localparam int SIZE_W = 32;
   localparam int BYTES_W = 40;
   localparam int WARM_W = 32;
   localparam int EV_W = 13;
   localparam int CNT32_W = 32;
   localparam int STAT_W = 48;
   localparam int LCG_W = 48;
   localparam int HALF_W = 24;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 40;
   localparam logic [CSR_IDX_W-1:0] CSR_CACHE_BYTES = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WARMUP = 1'd1;
   localparam logic [LCG_W-1:0] LCG_SEED = 48'h0004_0003_0002;
   localparam logic [HALF_W-1:0] LCG_MUL_LO = 24'hECE66D;
   localparam logic [10:0] LCG_MUL_HI = 11'h5DE;
   localparam logic [LCG_W-1:0] LCG_ADD = 48'hB;
endpackage
`default_nettype wire

// File: rtl/rrc_if.sv
// request and response channel interfaces
`default_nettype none
interface rrc_req_if;
   logic valid;
   logic ready;
   logic [rrc_pkg::ID_W-1:0] file_id;
   logic [rrc_pkg::SIZE_W-1:0] object_size;
   modport source (output valid, output file_id, output object_size, input ready);
   modport sink (input valid, input file_id, input object_size, output ready);
endinterface

interface rrc_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   logic inserted;
   logic [rrc_pkg::EV_W-1:0] evictions;
   logic [rrc_pkg::CNT32_W-1:0] counted_requests;
   logic [rrc_pkg::CNT32_W-1:0] counted_hits;
   logic [rrc_pkg::STAT_W-1:0] bytes_requested;
   logic [rrc_pkg::STAT_W-1:0] bytes_hit;
   modport source (output valid, output hit, output inserted, output evictions,
      output counted_requests, output counted_hits, output bytes_requested,
      output bytes_hit, input ready);
   modport sink (input valid, input hit, input inserted, input evictions,
      input counted_requests, input counted_hits, input bytes_requested,
      input bytes_hit, output ready);
endinterface
`default_nettype wire

// File: rtl/rrc_ram.sv
// generic single write, single read ram with registered read
`default_nettype none
module rrc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = rrc_pkg::ENTRIES_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// File: rtl/random_replacement_object_cache.sv
// top level of the random replacement object cache
//
//  channel  | dir | handshake          | payload
//  req_if   | in  | valid/ready        | file_id, object_size
//  rsp_if   | out | valid/ready        | hit, inserted, evictions, four statistics
//  csr_*    | in  | write enable only  | csr_index, csr_wr_data
//
// one request at a time; lookup walks the entry ram one entry per cycle up to
// entry_count, and each eviction steps through the generator multiply,
// victim scaling and two reads through the one ram port
// synchronous active high reset clears control and statistics; the entry ram
// needs no clearing since only slots below entry_count are ever read
// a finished response waits in its register; the next request is accepted
// while it waits, and a later result stalls in the done state until taken
`default_nettype none
module random_replacement_object_cache #(
   parameter int ENTRIES = rrc_pkg::ENTRIES_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   rrc_req_if.sink                                req_if,
   rrc_rsp_if.source                              rsp_if,
   input  wire logic                              csr_wr_en,
   input  wire logic [rrc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [rrc_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int HW = rrc_pkg::HALF_W;
   localparam int ENT_W = rrc_pkg::ID_W + rrc_pkg::SIZE_W;
   localparam logic [CNT_W-1:0] FULL = CNT_W'(ENTRIES);

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b000000000001,
      ST_SEARCH = 12'b000000000010,
      ST_STATS  = 12'b000000000100,
      ST_EVICT  = 12'b000000001000,
      ST_LCG1   = 12'b000000010000,
      ST_LCG2   = 12'b000000100000,
      ST_VIC1   = 12'b000001000000,
      ST_VIC2   = 12'b000010000000,
      ST_RDV    = 12'b000100000000,
      ST_RDL    = 12'b001000000000,
      ST_MOVE   = 12'b010000000000,
      ST_DONE   = 12'b100000000000
   } state_type;

   // control state
   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic pend_ff, pend_in;
   logic hit_ff, hit_in;
   logic ins_ff, ins_in;
   logic counted_ff, counted_in;
   logic [rrc_pkg::EV_W-1:0] ev_ff, ev_in;
   logic [rrc_pkg::BYTES_W-1:0] used_ff, used_in;
   logic [rrc_pkg::LCG_W-1:0] lcg_ff, lcg_in;
   logic [rrc_pkg::CNT32_W-1:0] total_ff, total_in;
   logic [rrc_pkg::CNT32_W-1:0] st_req_ff, st_req_in;
   logic [rrc_pkg::CNT32_W-1:0] st_hit_ff, st_hit_in;
   logic [rrc_pkg::STAT_W-1:0] st_breq_ff, st_breq_in;
   logic [rrc_pkg::STAT_W-1:0] st_bhit_ff, st_bhit_in;
   logic [rrc_pkg::BYTES_W-1:0] cache_bytes_ff;
   logic [rrc_pkg::WARM_W-1:0] warmup_ff;
   logic rsp_valid_ff, rsp_valid_in;

   // payload state
   logic [rrc_pkg::ID_W-1:0] id_ff, id_in;
   logic [rrc_pkg::SIZE_W-1:0] size_ff, size_in;
   logic [2*HW-1:0] p_ll_ff, p_ll_in;
   logic [HW-1:0] p_mid_ff, p_mid_in;
   logic [CNT_W+HW-1:0] q_hi_ff, q_hi_in, q_lo_ff, q_lo_in;
   logic [IDX_W-1:0] victim_ff, victim_in;
   logic [ENT_W-1:0] last_ent;

   logic rsp_hit_ff, rsp_hit_in, rsp_ins_ff, rsp_ins_in;
   logic [rrc_pkg::EV_W-1:0] rsp_ev_ff, rsp_ev_in;
   logic [rrc_pkg::CNT32_W-1:0] rsp_req_ff, rsp_req_in, rsp_hits_ff, rsp_hits_in;
   logic [rrc_pkg::STAT_W-1:0] rsp_breq_ff, rsp_breq_in, rsp_bhit_ff, rsp_bhit_in;

   // entry ram
   logic ram_we;
   logic [IDX_W-1:0] ram_waddr, ram_raddr;
   logic [ENT_W-1:0] ram_wdata, ram_rdata;

   rrc_ram #(.WIDTH(ENT_W), .DEPTH(ENTRIES)) u_entries (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // helpers
   logic [rrc_pkg::BYTES_W:0] fill_sum;
   logic room;
   logic [rrc_pkg::STAT_W:0] breq_sum, bhit_sum;
   logic [CNT_W+HW:0] t_sum;
   logic [CNT_W:0] t_val;
   logic [rrc_pkg::CNT32_W-1:0] total_nxt;
   logic rsp_free;

   assign fill_sum = {1'b0, used_ff} + (rrc_pkg::BYTES_W + 1)'(size_ff);
   assign room = (fill_sum <= {1'b0, cache_bytes_ff}) && (count_ff < FULL);
   assign breq_sum = {1'b0, st_breq_ff} + (rrc_pkg::STAT_W + 1)'(size_ff);
   assign bhit_sum = {1'b0, st_bhit_ff} + (rrc_pkg::STAT_W + 1)'(size_ff);
   assign t_sum = {1'b0, q_hi_ff} + (CNT_W + HW + 1)'(q_lo_ff[CNT_W+HW-1:HW]);
   assign t_val = t_sum[CNT_W+HW:HW];
   assign total_nxt = (&total_ff) ? total_ff : total_ff + 1'b1;
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;
   assign last_ent = ram_rdata;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.hit = rsp_hit_ff;
   assign rsp_if.inserted = rsp_ins_ff;
   assign rsp_if.evictions = rsp_ev_ff;
   assign rsp_if.counted_requests = rsp_req_ff;
   assign rsp_if.counted_hits = rsp_hits_ff;
   assign rsp_if.bytes_requested = rsp_breq_ff;
   assign rsp_if.bytes_hit = rsp_bhit_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      scan_in = scan_ff;
      pend_in = pend_ff;
      hit_in = hit_ff;
      ins_in = ins_ff;
      counted_in = counted_ff;
      ev_in = ev_ff;
      used_in = used_ff;
      lcg_in = lcg_ff;
      total_in = total_ff;
      st_req_in = st_req_ff;
      st_hit_in = st_hit_ff;
      st_breq_in = st_breq_ff;
      st_bhit_in = st_bhit_ff;
      id_in = id_ff;
      size_in = size_ff;
      p_ll_in = p_ll_ff;
      p_mid_in = p_mid_ff;
      q_hi_in = q_hi_ff;
      q_lo_in = q_lo_ff;
      victim_in = victim_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_hit_in = rsp_hit_ff;
      rsp_ins_in = rsp_ins_ff;
      rsp_ev_in = rsp_ev_ff;
      rsp_req_in = rsp_req_ff;
      rsp_hits_in = rsp_hits_ff;
      rsp_breq_in = rsp_breq_ff;
      rsp_bhit_in = rsp_bhit_ff;
      ram_we = 1'b0;
      ram_waddr = count_ff[IDX_W-1:0];
      ram_wdata = {id_ff, size_ff};
      ram_raddr = scan_ff[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               id_in = req_if.file_id;
               size_in = req_if.object_size;
               total_in = total_nxt;
               counted_in = total_nxt > warmup_ff;
               scan_in = '0;
               pend_in = 1'b0;
               hit_in = 1'b0;
               ins_in = 1'b0;
               ev_in = '0;
               state_in = ST_SEARCH;
            end
         end
         // one entry read per cycle, compared the cycle after
         ST_SEARCH: begin
            if (pend_ff && (ram_rdata[ENT_W-1:rrc_pkg::SIZE_W] == id_ff)) begin
               hit_in = 1'b1;
               state_in = ST_STATS;
            end else if (scan_ff < count_ff) begin
               scan_in = scan_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               state_in = ST_STATS;
            end
         end
         ST_STATS: begin
            if (counted_ff) begin
               if (!(&st_req_ff)) st_req_in = st_req_ff + 1'b1;
               st_breq_in = breq_sum[rrc_pkg::STAT_W] ? '1 : breq_sum[rrc_pkg::STAT_W-1:0];
               if (hit_ff) begin
                  if (!(&st_hit_ff)) st_hit_in = st_hit_ff + 1'b1;
                  st_bhit_in = bhit_sum[rrc_pkg::STAT_W] ? '1
                             : bhit_sum[rrc_pkg::STAT_W-1:0];
               end
            end
            if (hit_ff || (rrc_pkg::BYTES_W'(size_ff) > cache_bytes_ff)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_EVICT;
            end
         end
         ST_EVICT: begin
            if (room) begin
               ram_we = 1'b1;
               count_in = count_ff + 1'b1;
               used_in = fill_sum[rrc_pkg::BYTES_W-1:0];
               ins_in = 1'b1;
               state_in = ST_DONE;
            end else if (count_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_LCG1;
            end
         end
         // generator step split into partial products mod 2^48
         ST_LCG1: begin
            p_ll_in = lcg_ff[HW-1:0] * rrc_pkg::LCG_MUL_LO;
            p_mid_in = HW'(lcg_ff[HW-1:0] * rrc_pkg::LCG_MUL_HI)
                     + HW'(lcg_ff[2*HW-1:HW] * rrc_pkg::LCG_MUL_LO);
            state_in = ST_LCG2;
         end
         ST_LCG2: begin
            lcg_in = p_ll_ff + {p_mid_ff, {HW{1'b0}}} + rrc_pkg::LCG_ADD;
            state_in = ST_VIC1;
         end
         ST_VIC1: begin
            q_hi_in = count_ff * lcg_ff[2*HW-1:HW];
            q_lo_in = count_ff * lcg_ff[HW-1:0];
            state_in = ST_VIC2;
         end
         ST_VIC2: begin
            if (t_val < {1'b0, count_ff}) begin
               victim_in = t_val[IDX_W-1:0];
            end else begin
               victim_in = IDX_W'(count_ff - 1'b1);
            end
            state_in = ST_RDV;
         end
         ST_RDV: begin
            ram_raddr = victim_ff;
            state_in = ST_RDL;
         end
         // victim size arrives; fetch the last entry
         ST_RDL: begin
            used_in = used_ff - rrc_pkg::BYTES_W'(ram_rdata[rrc_pkg::SIZE_W-1:0]);
            ram_raddr = IDX_W'(count_ff - 1'b1);
            state_in = ST_MOVE;
         end
         // last entry fills the hole
         ST_MOVE: begin
            ram_we = 1'b1;
            ram_waddr = victim_ff;
            ram_wdata = last_ent;
            count_in = count_ff - 1'b1;
            ev_in = ev_ff + 1'b1;
            state_in = ST_EVICT;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in = hit_ff;
               rsp_ins_in = ins_ff;
               rsp_ev_in = ev_ff;
               rsp_req_in = st_req_ff;
               rsp_hits_in = st_hit_ff;
               rsp_breq_in = st_breq_ff;
               rsp_bhit_in = st_bhit_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         scan_ff <= '0;
         pend_ff <= 1'b0;
         hit_ff <= 1'b0;
         ins_ff <= 1'b0;
         counted_ff <= 1'b0;
         ev_ff <= '0;
         used_ff <= '0;
         lcg_ff <= rrc_pkg::LCG_SEED;
         total_ff <= '0;
         st_req_ff <= '0;
         st_hit_ff <= '0;
         st_breq_ff <= '0;
         st_bhit_ff <= '0;
         cache_bytes_ff <= '0;
         warmup_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         scan_ff <= scan_in;
         pend_ff <= pend_in;
         hit_ff <= hit_in;
         ins_ff <= ins_in;
         counted_ff <= counted_in;
         ev_ff <= ev_in;
         used_ff <= used_in;
         lcg_ff <= lcg_in;
         total_ff <= total_in;
         st_req_ff <= st_req_in;
         st_hit_ff <= st_hit_in;
         st_breq_ff <= st_breq_in;
         st_bhit_ff <= st_bhit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               rrc_pkg::CSR_CACHE_BYTES: cache_bytes_ff <= csr_wr_data[rrc_pkg::BYTES_W-1:0];
               rrc_pkg::CSR_WARMUP: warmup_ff <= csr_wr_data[rrc_pkg::WARM_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
      size_ff <= size_in;
      p_ll_ff <= p_ll_in;
      p_mid_ff <= p_mid_in;
      q_hi_ff <= q_hi_in;
      q_lo_ff <= q_lo_in;
      victim_ff <= victim_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_ins_ff <= rsp_ins_in;
      rsp_ev_ff <= rsp_ev_in;
      rsp_req_ff <= rsp_req_in;
      rsp_hits_ff <= rsp_hits_in;
      rsp_breq_ff <= rsp_breq_in;
      rsp_bhit_ff <= rsp_bhit_in;
   end
endmodule
`default_nettype wire
